// ----- rtl/core/bmt_pkg.sv -----
// Shared types and constants for the bounded multiset table.
package bmt_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned CMD_W        = 2;
  localparam int unsigned FIELD_W      = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_COUNT  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

endpackage

// ----- rtl/core/bmt_req_if.sv -----
// Request channel: command and value with valid/ready handshake.
interface bmt_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [bmt_pkg::CMD_W-1:0]            command;
  logic signed [bmt_pkg::VALUE_W-1:0]   value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

// ----- rtl/core/bmt_rsp_if.sv -----
// Response channel: success, match count and occupancy with valid/ready handshake.
interface bmt_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         success;
  logic [bmt_pkg::FIELD_W-1:0]  match_count;
  logic [bmt_pkg::FIELD_W-1:0]  occupancy;

  modport source (output valid, output success, output match_count, output occupancy,
                  input ready);
  modport sink   (input valid, input success, input match_count, input occupancy,
                  output ready);
endinterface

// ----- rtl/core/bmt_cell.sv -----
// One table cell: holds an entry and advances the scan probe by one position.
module bmt_cell #(
  parameter int unsigned CAPACITY = bmt_pkg::CAPACITY_DEF,
  parameter int unsigned IDX      = 0,
  localparam int unsigned CW      = $clog2(CAPACITY + 1),
  localparam int unsigned PW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [bmt_pkg::VALUE_W-1:0] key_i,
  input  logic [CW-1:0]               count_i,
  input  logic                        wr_en_i,
  input  logic [PW-1:0]               wr_idx_i,
  input  logic [bmt_pkg::VALUE_W-1:0] wr_data_i,
  input  logic                        probe_valid_i,
  input  logic [CW-1:0]               hits_i,
  input  logic                        found_i,
  input  logic [PW-1:0]               pos_i,
  input  logic [bmt_pkg::VALUE_W-1:0] last_i,
  output logic                        probe_valid_o,
  output logic [CW-1:0]               hits_o,
  output logic                        found_o,
  output logic [PW-1:0]               pos_o,
  output logic [bmt_pkg::VALUE_W-1:0] last_o
);

  logic [bmt_pkg::VALUE_W-1:0] entry_q;
  logic                        valid_q;
  logic [CW-1:0]               hits_q, hits_d;
  logic                        found_q, found_d;
  logic [PW-1:0]               pos_q, pos_d;
  logic [bmt_pkg::VALUE_W-1:0] last_q, last_d;
  logic                        in_use;
  logic                        hit;

  // Only occupied positions take part in the scan.
  assign in_use = (CW'(IDX) < count_i);
  assign hit    = in_use && (entry_q == key_i);

  always_comb begin
    hits_d  = hits_i + CW'(hit);
    found_d = found_i | hit;
    pos_d   = found_i ? pos_i : PW'(IDX);
    // Pick up the last occupied entry as the probe passes it.
    last_d  = (CW'(IDX + 1) == count_i) ? entry_q : last_i;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_idx_i == PW'(IDX))) begin
      entry_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= probe_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    hits_q  <= hits_d;
    found_q <= found_d;
    pos_q   <= pos_d;
    last_q  <= last_d;
  end

  assign probe_valid_o = valid_q;
  assign hits_o        = hits_q;
  assign found_o       = found_q;
  assign pos_o         = pos_q;
  assign last_o        = last_q;

endmodule

// ----- rtl/core/bounded_multiset_table.sv -----
// Top level of the bounded multiset table: cell chain, sequencer and result register.
//
// Usage: requests arrive on req_i (command, value) and each one returns exactly
// one beat on rsp_o (success, match_count, occupancy). Add stores the value at
// the first free position; remove overwrites the first match with the last
// entry; count reports how many occupied entries equal the value; clear empties
// the table.
// Timing: add and clear put their result beat up in the cycle after acceptance.
// Remove and count send a probe down the chain of CAPACITY cells, one cell per
// cycle; the scan result is then latched in ST_SCAN and moved into the result
// register in ST_FINISH once that register is free.
// Throughput: one request at a time; add and clear every cycle when the result
// is drained; remove and count hold off new requests until their beat is written.
// Reset: occupancy clears to zero and no beat is pending; stored entries are
// left as they are and only read below the occupancy.
// Stall: the result register holds while rsp_o.ready is low; a new request is
// taken only when that register is free or being drained in the same cycle.
module bounded_multiset_table #(
  parameter int unsigned CAPACITY = bmt_pkg::CAPACITY_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bmt_req_if.sink   req_i,
  bmt_rsp_if.source rsp_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned VW = bmt_pkg::VALUE_W;
  localparam int unsigned FW = bmt_pkg::FIELD_W;

  bmt_pkg::state_e state_q, state_d;
  bmt_pkg::cmd_e   cmd_q, req_cmd;
  logic [VW-1:0]   key_q;
  logic [VW-1:0]   scan_key;
  logic [CW-1:0]   count_q, count_d;

  // Pending result of a scan, held until the result register frees up.
  logic            res_success_q, res_success_d;
  logic [FW-1:0]   res_hits_q, res_hits_d;

  // Result register.
  logic            out_valid_q, out_valid_d;
  logic            out_success_q, out_success_d;
  logic [FW-1:0]   out_hits_q, out_hits_d;
  logic [FW-1:0]   out_occ_q, out_occ_d;

  logic            accept;
  logic            out_free;
  logic            start_probe;
  logic            wr_en;
  logic [PW-1:0]   wr_idx;
  logic [VW-1:0]   wr_data;

  // Probe chain between cells.
  logic            pv    [CAPACITY+1];
  logic [CW-1:0]   phits [CAPACITY+1];
  logic            pfound[CAPACITY+1];
  logic [PW-1:0]   ppos  [CAPACITY+1];
  logic [VW-1:0]   plast [CAPACITY+1];

  assign req_cmd  = bmt_pkg::cmd_e'(req_i.command);
  assign out_free = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == bmt_pkg::ST_IDLE) && out_free;
  assign accept   = req_i.valid && req_i.ready;

  // The first cell sees the probe in the accept cycle, before key_q loads,
  // so hand it the request value directly in that cycle.
  assign scan_key = accept ? req_i.value : key_q;

  // Inject a fresh probe at the head of the chain.
  assign pv[0]     = start_probe;
  assign phits[0]  = '0;
  assign pfound[0] = 1'b0;
  assign ppos[0]   = '0;
  assign plast[0]  = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    bmt_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (i)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .key_i         (scan_key),
      .count_i       (count_q),
      .wr_en_i       (wr_en),
      .wr_idx_i      (wr_idx),
      .wr_data_i     (wr_data),
      .probe_valid_i (pv[i]),
      .hits_i        (phits[i]),
      .found_i       (pfound[i]),
      .pos_i         (ppos[i]),
      .last_i        (plast[i]),
      .probe_valid_o (pv[i+1]),
      .hits_o        (phits[i+1]),
      .found_o       (pfound[i+1]),
      .pos_o         (ppos[i+1]),
      .last_o        (plast[i+1])
    );
  end

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    res_success_d = res_success_q;
    res_hits_d    = res_hits_q;
    out_valid_d   = out_valid_q && !rsp_o.ready;
    out_success_d = out_success_q;
    out_hits_d    = out_hits_q;
    out_occ_d     = out_occ_q;
    start_probe   = 1'b0;
    wr_en         = 1'b0;
    wr_idx        = count_q[PW-1:0];
    wr_data       = req_i.value;

    case (state_q)
      bmt_pkg::ST_IDLE: begin
        if (accept) begin
          case (req_cmd)
            bmt_pkg::CMD_ADD: begin
              // Append when there is room; report the new occupancy either way.
              if (count_q < CW'(CAPACITY)) begin
                wr_en   = 1'b1;
                count_d = count_q + CW'(1);
              end
              out_valid_d   = 1'b1;
              out_success_d = (count_q < CW'(CAPACITY));
              out_hits_d    = '0;
              out_occ_d     = FW'(count_d);
            end
            bmt_pkg::CMD_CLEAR: begin
              count_d       = '0;
              out_valid_d   = 1'b1;
              out_success_d = 1'b1;
              out_hits_d    = '0;
              out_occ_d     = '0;
            end
            default: begin
              // Remove and count walk the chain.
              start_probe = 1'b1;
              state_d     = bmt_pkg::ST_SCAN;
            end
          endcase
        end
      end
      bmt_pkg::ST_SCAN: begin
        if (pv[CAPACITY]) begin
          if (cmd_q == bmt_pkg::CMD_REMOVE) begin
            // Move the last entry into the hole and shrink.
            if (pfound[CAPACITY]) begin
              wr_en   = 1'b1;
              wr_idx  = ppos[CAPACITY];
              wr_data = plast[CAPACITY];
              count_d = count_q - CW'(1);
            end
            res_success_d = pfound[CAPACITY];
            res_hits_d    = '0;
          end else begin
            res_success_d = (phits[CAPACITY] != '0);
            res_hits_d    = FW'(phits[CAPACITY]);
          end
          state_d = bmt_pkg::ST_FINISH;
        end
      end
      bmt_pkg::ST_FINISH: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_success_d = res_success_q;
          out_hits_d    = res_hits_q;
          out_occ_d     = FW'(count_q);
          state_d       = bmt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bmt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bmt_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: hold request fields and results, no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= req_cmd;
      key_q <= req_i.value;
    end
    res_success_q <= res_success_d;
    res_hits_q    <= res_hits_d;
    out_success_q <= out_success_d;
    out_hits_q    <= out_hits_d;
    out_occ_q     <= out_occ_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.success     = out_success_q;
  assign rsp_o.match_count = out_hits_q;
  assign rsp_o.occupancy   = out_occ_q;

endmodule
